// ===== sv/ksms_pkg.sv =====
package ksms_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned RankW   = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_SELECT_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RANK_INDEX  = 2'd1;

  localparam logic MODE_KTH    = 1'b0;
  localparam logic MODE_MEDIAN = 1'b1;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    logic ins;
    logic shf;
  } cell_ctrl_t;

endpackage

// ===== sv/ksms_cell.sv =====
module ksms_cell (
  input  logic                 clk_i,
  input  ksms_pkg::cell_ctrl_t ctrl_i,
  input  logic                 empty_i,
  input  ksms_pkg::sample_t    x_i,
  input  ksms_pkg::sample_t    prev_val_i,
  input  logic                 prev_lt_i,
  input  ksms_pkg::sample_t    next_val_i,
  output ksms_pkg::sample_t    val_o,
  output logic                 lt_o
);

  ksms_pkg::sample_t val_q;
  ksms_pkg::sample_t val_d;

  assign lt_o  = empty_i | (x_i < val_q);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (lt_o) begin
        val_d = prev_lt_i ? prev_val_i : x_i;
      end
    end else if (ctrl_i.shf) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== sv/ksms_chain.sv =====
module ksms_chain #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned CntW        = 7
) (
  input  logic                 clk_i,
  input  ksms_pkg::cell_ctrl_t ctrl_i,
  input  logic [CntW-1:0]      count_i,
  input  ksms_pkg::sample_t    x_i,
  output ksms_pkg::sample_t    head0_o,
  output ksms_pkg::sample_t    head1_o
);

  localparam int unsigned Second = (STORE_DEPTH > 1) ? 1 : 0;

  ksms_pkg::sample_t val   [STORE_DEPTH];
  logic              lt    [STORE_DEPTH];

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    ksms_pkg::sample_t prev_val;
    ksms_pkg::sample_t next_val;
    logic              prev_lt;

    if (i == 0) begin : g_first
      assign prev_val = x_i;
      assign prev_lt  = 1'b0;
    end else begin : g_mid
      assign prev_val = val[i-1];
      assign prev_lt  = lt[i-1];
    end

    if (i == STORE_DEPTH - 1) begin : g_end
      assign next_val = val[i];
    end else begin : g_link
      assign next_val = val[i+1];
    end

    ksms_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .empty_i    (Idx >= count_i),
      .x_i        (x_i),
      .prev_val_i (prev_val),
      .prev_lt_i  (prev_lt),
      .next_val_i (next_val),
      .val_o      (val[i]),
      .lt_o       (lt[i])
    );
  end

  assign head0_o = val[0];
  assign head1_o = val[Second];

endmodule

// ===== sv/kth_smallest_median_select.sv =====
// Loading: one sample item per cycle, inserted in sorted order along the cell chain.
// Selection: after the item marked last, the chain shifts towards its head once per
// rank step until the target rank is at its head, and the result is then registered.
// Input stalls until that result registers; the next set may load while a result waits.
// Reset (rst_ni low, asynchronous): fill count and overflow flag clear, median mode,
// rank 0, no result pending; cell contents are undefined until written.
module kth_smallest_median_select #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [31:0]                    sample_i,
  input  logic                                  last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [31:0]                    value_o,
  output logic [$clog2(STORE_DEPTH+1)-1:0]      count_o,
  output logic                                  rank_invalid_o,
  output logic                                  overflowed_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ksms_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [ksms_pkg::RankW-1:0]            cfg_data_i
);

  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IdxW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CmpW = (CntW > ksms_pkg::RankW) ? CntW : ksms_pkg::RankW;
  localparam logic [CntW-1:0] Full = CntW'(STORE_DEPTH);

  typedef enum logic {
    ST_LOAD,
    ST_SEEK
  } state_e;

  state_e                  state_q;
  logic                    mode_q;
  logic [ksms_pkg::RankW-1:0] rank_q;
  logic [CntW-1:0]         fill_q;
  logic                    ovf_q;
  logic [IdxW-1:0]         remain_q;
  logic                    even_q;
  logic                    bad_q;
  logic [CntW-1:0]         set_cnt_q;
  logic                    set_ovf_q;

  logic                    out_valid_q;
  ksms_pkg::sample_t       value_q;
  logic [CntW-1:0]         count_q;
  logic                    rank_invalid_q;
  logic                    overflowed_q;

  logic                    in_acc;
  logic                    store_ok;
  logic [CntW-1:0]         n_c;
  logic [CmpW-1:0]         n_ext;
  logic [CmpW-1:0]         k_ext;
  logic                    bad_c;
  logic [CntW-1:0]         half_c;
  logic [IdxW-1:0]         target_c;
  logic                    finish;
  ksms_pkg::cell_ctrl_t    ctrl;
  ksms_pkg::sample_t       head0;
  ksms_pkg::sample_t       head1;
  logic signed [32:0]      pair_sum;
  ksms_pkg::sample_t       result_c;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;
  assign store_ok    = fill_q < Full;
  assign n_c         = store_ok ? fill_q + CntW'(1) : fill_q;
  assign n_ext       = CmpW'(n_c);
  assign k_ext       = CmpW'(rank_q);
  assign bad_c       = (mode_q == ksms_pkg::MODE_KTH) && (k_ext >= n_ext);
  assign half_c      = n_c >> 1;

  always_comb begin
    if (mode_q == ksms_pkg::MODE_KTH) begin
      target_c = bad_c ? '0 : k_ext[IdxW-1:0];
    end else if (n_c[0]) begin
      target_c = half_c[IdxW-1:0];
    end else begin
      target_c = half_c[IdxW-1:0] - IdxW'(1);
    end
  end

  assign ctrl.ins = in_acc & store_ok;
  assign ctrl.shf = (state_q == ST_SEEK) && (remain_q != '0);
  assign finish   = (state_q == ST_SEEK) && (remain_q == '0) && (!out_valid_q || out_ready_i);

  ksms_chain #(
    .STORE_DEPTH (STORE_DEPTH),
    .CntW        (CntW)
  ) u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .count_i (fill_q),
    .x_i     (sample_i),
    .head0_o (head0),
    .head1_o (head1)
  );

  assign pair_sum = {head0[31], head0} + {head1[31], head1};

  always_comb begin
    priority if (bad_q) begin
      result_c = '0;
    end else if (even_q) begin
      result_c = pair_sum[32:1];
    end else begin
      result_c = head0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ksms_pkg::MODE_MEDIAN;
      rank_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ksms_pkg::CFG_SELECT_MODE: mode_q <= cfg_data_i[0];
        ksms_pkg::CFG_RANK_INDEX:  rank_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_LOAD;
      fill_q         <= '0;
      ovf_q          <= 1'b0;
      remain_q       <= '0;
      even_q         <= 1'b0;
      bad_q          <= 1'b0;
      set_cnt_q      <= '0;
      set_ovf_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      value_q        <= '0;
      count_q        <= '0;
      rank_invalid_q <= 1'b0;
      overflowed_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !finish) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (last_i) begin
              state_q   <= ST_SEEK;
              fill_q    <= n_c;
              set_cnt_q <= n_c;
              set_ovf_q <= ovf_q | !store_ok;
              remain_q  <= target_c;
              bad_q     <= bad_c;
              even_q    <= (mode_q == ksms_pkg::MODE_MEDIAN) && !n_c[0];
            end else begin
              fill_q <= n_c;
              ovf_q  <= ovf_q | !store_ok;
            end
          end
        end
        ST_SEEK: begin
          if (remain_q != '0) begin
            remain_q <= remain_q - IdxW'(1);
          end else if (finish) begin
            out_valid_q    <= 1'b1;
            value_q        <= result_c;
            count_q        <= set_cnt_q;
            rank_invalid_q <= bad_q;
            overflowed_q   <= set_ovf_q;
            fill_q         <= '0;
            ovf_q          <= 1'b0;
            state_q        <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign count_o        = count_q;
  assign rank_invalid_o = rank_invalid_q;
  assign overflowed_o   = overflowed_q;

endmodule

// ===== sv/ksms_checker.sv =====
module ksms_checker #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [31:0]               value_o,
  input logic [$clog2(STORE_DEPTH+1)-1:0] count_o,
  input logic                             rank_invalid_o,
  input logic                             overflowed_o
);

  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(count_o))
    else $error("result item changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o != '0) && (count_o <= CntW'(STORE_DEPTH)))
    else $error("result count out of range");

  a_bad_rank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rank_invalid_o |-> value_o == '0)
    else $error("invalid rank with non-zero value");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflowed_o |-> count_o == CntW'(STORE_DEPTH))
    else $error("overflow flagged with store not full");

endmodule

bind kth_smallest_median_select ksms_checker #(
  .STORE_DEPTH (STORE_DEPTH)
) u_ksms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .value_o        (value_o),
  .count_o        (count_o),
  .rank_invalid_o (rank_invalid_o),
  .overflowed_o   (overflowed_o)
);

// ===== sim/kth_select_checker.sv =====
`timescale 1ns / 100ps

module kth_select_checker #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned CountW      = $clog2(STORE_DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  ksms_pkg::sample_t                   sample_i,
  input  logic                                last_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  ksms_pkg::sample_t                   value_i,
  input  logic [CountW-1:0]                   count_i,
  input  logic                                rank_invalid_i,
  input  logic                                overflowed_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [ksms_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ksms_pkg::RankW-1:0]          cfg_data_i,
  output int                                  mismatch_count_o,
  output int                                  outstanding_o
);

  typedef struct packed {
    ksms_pkg::sample_t   value;
    logic [CountW-1:0]   count;
    logic                rank_invalid;
    logic                overflowed;
  } select_result_t;

  ksms_pkg::sample_t          held[STORE_DEPTH];
  int                         fill_q;
  logic                       overflow_q;
  logic                       mode_q;
  logic [ksms_pkg::RankW-1:0] rank_q;
  int                         mismatches;
  select_result_t             pending_results[$];

  // Sort the held samples in place, then pick by rank or form the median.
  function automatic select_result_t select_from_set();
    select_result_t                    r;
    ksms_pkg::sample_t                 key;
    logic signed [ksms_pkg::SampleW:0] pair_sum;
    int                                j;
    for (int i = 1; i < fill_q; i++) begin
      key = held[i];
      j = i - 1;
      while (j >= 0 && held[j] > key) begin
        held[j + 1] = held[j];
        j--;
      end
      held[j + 1] = key;
    end
    r.count        = CountW'(fill_q);
    r.overflowed   = overflow_q;
    r.rank_invalid = 1'b0;
    r.value        = '0;
    if (mode_q == ksms_pkg::MODE_KTH) begin
      if (rank_q >= fill_q) begin
        r.rank_invalid = 1'b1;
      end else begin
        r.value = held[rank_q];
      end
    end else if (fill_q[0]) begin
      r.value = held[(fill_q - 1) / 2];
    end else begin
      pair_sum = held[fill_q / 2 - 1] + held[fill_q / 2];
      r.value  = pair_sum[ksms_pkg::SampleW:1];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    select_result_t want;
    select_result_t got;
    if (!rst_ni) begin
      fill_q     = 0;
      overflow_q = 1'b0;
      mode_q     = ksms_pkg::MODE_MEDIAN;
      rank_q     = '0;
      mismatches = 0;
      pending_results.delete();
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == ksms_pkg::CFG_SELECT_MODE) begin
          mode_q = cfg_data_i[0];
        end else if (cfg_index_i == ksms_pkg::CFG_RANK_INDEX) begin
          rank_q = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (fill_q < STORE_DEPTH) begin
          held[fill_q] = sample_i;
          fill_q++;
        end else begin
          overflow_q = 1'b1;
        end
        if (last_i) begin
          pending_results.push_back(select_from_set());
          fill_q     = 0;
          overflow_q = 1'b0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        got.value        = value_i;
        got.count        = count_i;
        got.rank_invalid = rank_invalid_i;
        got.overflowed   = overflowed_i;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result value=%0d count=%0d rank_invalid=%0b overflowed=%0b",
                     $realtime, got.value, got.count, got.rank_invalid, got.overflowed);
          end
        end else begin
          want = pending_results.pop_front();
          if (want.value != got.value || want.count != got.count ||
              want.rank_invalid != got.rank_invalid || want.overflowed != got.overflowed) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch expected value=%0d count=%0d rank_invalid=%0b %s%0b",
                       $realtime, want.value, want.count, want.rank_invalid, "overflowed=",
                       want.overflowed);
              $display("%0t:                 actual value=%0d count=%0d rank_invalid=%0b %s%0b",
                       $realtime, got.value, got.count, got.rank_invalid, "overflowed=",
                       got.overflowed);
            end
          end
        end
      end
      mismatch_count_o <= mismatches;
      outstanding_o    <= pending_results.size();
    end
  end

endmodule

// ===== sim/tb_kth_smallest_median_select.sv =====
`timescale 1ns / 100ps

module tb_kth_smallest_median_select;

  typedef logic [ksms_pkg::RankW-1:0] rank_t;

  localparam int unsigned StoreDepth   = 64;
  localparam int unsigned CountW       = $clog2(StoreDepth + 1);
  localparam int unsigned SettleCycles = StoreDepth + 8;
  localparam int unsigned TargetItems  = 2000;
  localparam logic [ksms_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam rank_t             RANK_TOP   = '1;
  localparam ksms_pkg::sample_t SAMPLE_MAX = 32'sh7fffffff;
  localparam ksms_pkg::sample_t SAMPLE_MIN = 32'sh80000000;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  ksms_pkg::sample_t            sample_i       = '0;
  logic                         last_i         = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i    = 1'b0;
  ksms_pkg::sample_t            value_o;
  logic [CountW-1:0]            count_o;
  logic                         rank_invalid_o;
  logic                         overflowed_o;
  logic                         cfg_valid_i    = 1'b0;
  logic                         cfg_ready_o;
  logic [ksms_pkg::CfgIdxW-1:0] cfg_index_i    = '0;
  rank_t                        cfg_data_i     = '0;

  int                mismatch_count;
  int                outstanding;
  logic              calm = 1'b0;
  ksms_pkg::sample_t set_buf[$];

  kth_smallest_median_select #(
    .STORE_DEPTH(StoreDepth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .count_o       (count_o),
    .rank_invalid_o(rank_invalid_o),
    .overflowed_o  (overflowed_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  kth_select_checker #(
    .STORE_DEPTH(StoreDepth)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .sample_i        (sample_i),
    .last_i          (last_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .value_i         (value_o),
    .count_i         (count_o),
    .rank_invalid_i  (rank_invalid_o),
    .overflowed_i    (overflowed_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  always #2 clk_i = ~clk_i;

  function automatic ksms_pkg::sample_t rand_sample();
    ksms_pkg::sample_t r;
    case ($urandom_range(0, 3))
      0: begin
        r = $urandom_range(0, 8);
        r = r - 4;
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       r = SAMPLE_MIN;
          1:       r = SAMPLE_MAX;
          2:       r = '0;
          default: r = -1;
        endcase
      end
      default: r = $urandom;
    endcase
    return r;
  endfunction

  task automatic send_item(input ksms_pkg::sample_t s, input logic is_last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_set();
    for (int i = 0; i < set_buf.size(); i++) begin
      send_item(set_buf[i], i == set_buf.size() - 1);
    end
    set_buf.delete();
  endtask

  task automatic cfg_put(input logic [ksms_pkg::CfgIdxW-1:0] idx, input rank_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_config(input logic mode, input rank_t rank, input logic stray);
    rank_t noise;
    noise = rank_t'($urandom);
    if (stray) begin
      cfg_put(CFG_UNUSED, noise);
    end
    cfg_put(ksms_pkg::CFG_SELECT_MODE, {noise[ksms_pkg::RankW-2:0], mode});
    cfg_put(ksms_pkg::CFG_RANK_INDEX, rank);
    cfg_valid_i <= 1'b0;
  endtask

  // hold input idle until every result is back and the selection logic has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int gap;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
    end
  end

  initial begin
    int    items_sent;
    int    n_sets;
    int    len;
    logic  mode;
    rank_t rank;
    items_sent = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_buf.push_back(SAMPLE_MAX);
    send_set();
    set_buf.push_back(SAMPLE_MIN);
    set_buf.push_back(SAMPLE_MAX);
    send_set();
    set_buf.push_back(SAMPLE_MAX);
    set_buf.push_back(SAMPLE_MAX);
    send_set();
    set_buf.push_back(SAMPLE_MIN);
    set_buf.push_back(SAMPLE_MIN);
    send_set();
    set_buf.push_back(-1);
    set_buf.push_back(0);
    send_set();
    set_buf.push_back(5);
    set_buf.push_back(-3);
    set_buf.push_back(5);
    send_set();
    drain();

    set_config(ksms_pkg::MODE_KTH, rank_t'(1), 1'b1);
    set_buf.push_back(SAMPLE_MAX);
    set_buf.push_back(SAMPLE_MIN);
    set_buf.push_back(0);
    send_set();
    set_buf.push_back(7);
    set_buf.push_back(7);
    send_set();
    set_buf.push_back(3);
    send_set();
    drain();

    set_config(ksms_pkg::MODE_KTH, RANK_TOP, 1'b0);
    set_buf.push_back(1);
    set_buf.push_back(2);
    send_set();
    drain();

    while (items_sent < TargetItems) begin
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0:       rank = '0;
        1:       rank = RANK_TOP;
        2:       rank = rank_t'($urandom_range(0, 7));
        default: rank = rank_t'($urandom);
      endcase
      set_config(mode, rank, $urandom_range(0, 7) == 0);
      calm = ($urandom_range(0, 3) == 0);
      n_sets = $urandom_range(1, 8);
      repeat (n_sets) begin
        case ($urandom_range(0, 15))
          0:       len = $urandom_range(StoreDepth + 1, StoreDepth + 6);
          1:       len = StoreDepth;
          2, 3:    len = $urandom_range(13, StoreDepth - 1);
          default: len = $urandom_range(1, 12);
        endcase
        for (int i = 0; i < len; i++) begin
          send_item(rand_sample(), i == len - 1);
        end
        items_sent += len;
      end
      drain();
    end

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== kth_smallest_median_select.f =====
sv/ksms_pkg.sv
sv/ksms_cell.sv
sv/ksms_chain.sv
sv/kth_smallest_median_select.sv
sv/ksms_checker.sv
sim/kth_select_checker.sv
sim/tb_kth_smallest_median_select.sv
